// File: design/portal_quad_visibility_test_assert.svh
// assertion macros for the portal quad visibility test
`ifndef PORTAL_QUAD_VISIBILITY_TEST_ASSERT_SVH
`define PORTAL_QUAD_VISIBILITY_TEST_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define PQVT_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
`define PQVT_NEVER(lbl, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) !(cond)) else $error(msg);
`else
`define PQVT_ASSERT(lbl, prop, msg)
`define PQVT_NEVER(lbl, cond, msg)
`endif
`endif

// File: design/pqvt_pkg.sv
// shared types and constants of the portal quad visibility test
package pqvt_pkg;
   localparam int COORD_FRAC_BITS_DEF = 16;
   localparam int COORD_W = 32;
   localparam int NUM_REGS = 7;
   localparam int CSR_ADDR_W = 6;
   localparam int CSR_DATA_W = 64;
   localparam int CSR_IDX_LSB = 3;
   localparam int ROWS = 3;
   localparam int CORNERS = 4;
   localparam int TERMS = 3;
   localparam int LANES = 8;
   localparam int QUOT_BITS = 30;
   localparam logic [QUOT_BITS-1:0] SCREEN_LIM = '1;

   // register map
   localparam int REG_ROW_X_LO = 0;
   localparam int REG_ROW_Y_LO = 2;
   localparam int REG_ROW_W_LO = 4;
   localparam int REG_VIEW_FWD = 6;

   // row order inside the transform arrays
   localparam int ROW_X = 0;
   localparam int ROW_Y = 1;
   localparam int ROW_W = 2;

   typedef logic signed [COORD_W-1:0] coord_type;
   typedef logic [CSR_DATA_W-1:0] csr_data_type;
endpackage

// File: design/pqvt_ifs.sv
// valid/ready channel interfaces for gap beats and result beats
interface pqvt_req_if import pqvt_pkg::*; ();
   logic valid;
   logic ready;
   coord_type corner_a_x;
   coord_type corner_a_y;
   coord_type corner_b_x;
   coord_type corner_b_y;
   coord_type bottom_height;
   coord_type top_height;
   logic from_home;

   modport source (output valid, output corner_a_x, output corner_a_y, output corner_b_x,
      output corner_b_y, output bottom_height, output top_height, output from_home,
      input ready);
   modport sink (input valid, input corner_a_x, input corner_a_y, input corner_b_x,
      input corner_b_y, input bottom_height, input top_height, input from_home,
      output ready);
endinterface

interface pqvt_rsp_if import pqvt_pkg::*; ();
   logic valid;
   logic ready;
   logic visible;

   modport source (output valid, output visible, input ready);
   modport sink (input valid, input visible, output ready);
endinterface

// File: design/portal_quad_visibility_test.sv
// channel   | dir | handshake         | payload
// req_chan  | in  | valid/ready       | two floor corners, bottom/top height, from_home
// rsp_chan  | out | valid/ready       | visible
// apb       | in  | psel/penable      | seven 64-bit camera registers at 8*i
// one gap beat enters per cycle unless the pipeline is frozen; a result passes stages a to e, the divider,
// stages f to h and the output register; the 30-stage restoring divider gives one quotient bit per stage
// the whole pipeline freezes while a result waits on rsp_chan.ready
// reset clears stage valid bits and the camera registers
`include "portal_quad_visibility_test_assert.svh"
module portal_quad_visibility_test import pqvt_pkg::*; #(
   parameter int COORD_FRAC_BITS = COORD_FRAC_BITS_DEF
) (
   input  logic clock,
   input  logic reset,
   pqvt_req_if.sink req_chan,
   pqvt_rsp_if.source rsp_chan,
   input  logic psel,
   input  logic penable,
   input  logic pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  csr_data_type pwdata,
   output csr_data_type prdata,
   output logic pready
);
   localparam int NUM_W = COORD_W + COORD_FRAC_BITS;
   localparam int CMP_W = COORD_W + QUOT_BITS;
   localparam logic signed [COORD_W-1:0] ONE = COORD_W'(1) << COORD_FRAC_BITS;
   localparam logic signed [66:0] T_MAX = 67'sd2147483647;
   localparam logic signed [66:0] T_MIN = -67'sd2147483648;
   localparam int LAST = QUOT_BITS - 1;

   // camera registers
   csr_data_type row_ff [NUM_REGS];
   logic [CSR_ADDR_W-CSR_IDX_LSB-1:0] csr_idx;
   logic csr_idx_ok;

   assign csr_idx = paddr[CSR_ADDR_W-1:CSR_IDX_LSB];
   assign csr_idx_ok = (32'(csr_idx) < NUM_REGS);
   assign pready = 1'b1;
   assign prdata = csr_idx_ok ? row_ff[csr_idx] : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_REGS; i++) row_ff[i] <= '0;
      end else if (psel && penable && pwrite && csr_idx_ok) begin
         row_ff[csr_idx] <= pwdata;
      end
   end

   coord_type coef [ROWS][4];
   coord_type fwd_x, fwd_y;

   always_comb begin
      for (int r = 0; r < ROWS; r++) begin
         coef[r][0] = row_ff[REG_ROW_X_LO + 2*r][31:0];
         coef[r][1] = row_ff[REG_ROW_X_LO + 2*r][63:32];
         coef[r][2] = row_ff[REG_ROW_X_LO + 2*r + 1][31:0];
         coef[r][3] = row_ff[REG_ROW_X_LO + 2*r + 1][63:32];
      end
   end
   assign fwd_x = row_ff[REG_VIEW_FWD][31:0];
   assign fwd_y = row_ff[REG_VIEW_FWD][63:32];

   logic en;
   logic o_valid_ff, o_vis_ff, o_same_ff;

   assign en = !o_valid_ff || rsp_chan.ready;
   assign req_chan.ready = en;
   assign rsp_chan.valid = o_valid_ff;
   assign rsp_chan.visible = o_vis_ff;

   // stage a: input register
   logic a_valid_ff, a_home_ff;
   coord_type a_ax_ff, a_ay_ff, a_bx_ff, a_by_ff, a_z0_ff, a_z1_ff;
   logic signed [COORD_W:0] a_dx_ff, a_dy_ff;

   // stage b: products
   logic b_valid_ff, b_home_ff;
   logic signed [63:0] b_p_ff [ROWS][CORNERS][TERMS];
   logic signed [64:0] b_fdy_ff, b_fdx_ff;
   logic signed [63:0] prod_in [ROWS][CORNERS][TERMS];
   coord_type cx [CORNERS];
   coord_type cy [CORNERS];
   coord_type cz [CORNERS];
   logic signed [64:0] fdy_in, fdx_in;

   // stage c: transformed corners
   logic c_valid_ff, c_home_ff, c_fwd_ff;
   coord_type c_t_ff [ROWS][CORNERS];
   coord_type t_in [ROWS][CORNERS];

   // stage d: magnitudes and signs
   logic d_valid_ff, d_home_ff, d_fwd_ff, d_pos_ff, d_neg_ff;
   logic [COORD_W-1:0] d_num_ff [LANES];
   logic [COORD_W-1:0] d_den_ff [CORNERS];
   logic d_sgn_ff [LANES];
   logic [COORD_W-1:0] num_in [LANES];
   logic [COORD_W-1:0] den_in [CORNERS];
   logic sgn_in [LANES];
   logic pos_in, neg_in;

   // stage e: overflow check and divider setup
   logic e_valid_ff, e_home_ff, e_fwd_ff, e_same_ff;
   logic e_ovf_ff [LANES];
   logic e_sgn_ff [LANES];
   logic [COORD_W-1:0] e_rem_ff [LANES];
   logic [QUOT_BITS-1:0] e_nq_ff [LANES];
   logic [COORD_W-1:0] e_den_ff [CORNERS];
   logic ovf_in [LANES];
   logic [COORD_W-1:0] rem0_in [LANES];
   logic [QUOT_BITS-1:0] nq0_in [LANES];

   // divider stages
   logic dv_valid_ff [QUOT_BITS];
   logic dv_home_ff [QUOT_BITS];
   logic dv_fwd_ff [QUOT_BITS];
   logic dv_same_ff [QUOT_BITS];
   logic dv_ovf_ff [QUOT_BITS][LANES];
   logic dv_sgn_ff [QUOT_BITS][LANES];
   logic [COORD_W-1:0] dv_rem_ff [QUOT_BITS][LANES];
   logic [QUOT_BITS-1:0] dv_nq_ff [QUOT_BITS][LANES];
   logic [COORD_W-1:0] dv_den_ff [QUOT_BITS][CORNERS];
   logic [COORD_W-1:0] dv_rem_in [QUOT_BITS][LANES];
   logic [QUOT_BITS-1:0] dv_nq_in [QUOT_BITS][LANES];

   // stage f: screen coordinates
   logic f_valid_ff, f_home_ff, f_fwd_ff, f_same_ff;
   coord_type f_s_ff [LANES];
   coord_type s_in [LANES];

   // stage g: edge differences and edge flags
   logic g_valid_ff, g_home_ff, g_fwd_ff, g_same_ff, g_edge_ff;
   coord_type g_d_ff [2][4];
   coord_type d_in [2][4];
   logic edge_in;

   // stage h: winding products
   logic h_valid_ff, h_home_ff, h_fwd_ff, h_same_ff, h_edge_ff;
   logic signed [63:0] h_m_ff [2];
   logic signed [63:0] h_n_ff [2];
   logic o_vis_in;

   // corners in order (a,z1) (b,z1) (b,z0) (a,z0)
   always_comb begin
      cx[0] = a_ax_ff; cy[0] = a_ay_ff; cz[0] = a_z1_ff;
      cx[1] = a_bx_ff; cy[1] = a_by_ff; cz[1] = a_z1_ff;
      cx[2] = a_bx_ff; cy[2] = a_by_ff; cz[2] = a_z0_ff;
      cx[3] = a_ax_ff; cy[3] = a_ay_ff; cz[3] = a_z0_ff;
      for (int r = 0; r < ROWS; r++) begin
         for (int k = 0; k < CORNERS; k++) begin
            prod_in[r][k][0] = coef[r][0] * cx[k];
            prod_in[r][k][1] = coef[r][1] * cy[k];
            prod_in[r][k][2] = coef[r][2] * cz[k];
         end
      end
      fdy_in = fwd_x * a_dy_ff;
      fdx_in = fwd_y * a_dx_ff;
   end

   // floor of the exact sum, plus offset, saturated
   always_comb begin
      logic signed [65:0] acc;
      logic signed [66:0] t;
      for (int r = 0; r < ROWS; r++) begin
         for (int k = 0; k < CORNERS; k++) begin
            acc = 66'(b_p_ff[r][k][0]) + 66'(b_p_ff[r][k][1]) + 66'(b_p_ff[r][k][2]);
            t = 67'(acc >>> COORD_FRAC_BITS) + 67'(coef[r][3]);
            if (t > T_MAX) t_in[r][k] = T_MAX[COORD_W-1:0];
            else if (t < T_MIN) t_in[r][k] = T_MIN[COORD_W-1:0];
            else t_in[r][k] = t[COORD_W-1:0];
         end
      end
   end

   always_comb begin
      coord_type w;
      pos_in = 1'b1;
      neg_in = 1'b1;
      for (int k = 0; k < CORNERS; k++) begin
         w = c_t_ff[ROW_W][k];
         pos_in = pos_in && (w > 0);
         neg_in = neg_in && (w < 0);
         den_in[k] = w[COORD_W-1] ? COORD_W'(-w) : COORD_W'(w);
         num_in[k] = c_t_ff[ROW_X][k][COORD_W-1] ? COORD_W'(-c_t_ff[ROW_X][k])
                                                 : COORD_W'(c_t_ff[ROW_X][k]);
         num_in[CORNERS+k] = c_t_ff[ROW_Y][k][COORD_W-1] ? COORD_W'(-c_t_ff[ROW_Y][k])
                                                         : COORD_W'(c_t_ff[ROW_Y][k]);
         sgn_in[k] = c_t_ff[ROW_X][k][COORD_W-1] ^ w[COORD_W-1];
         sgn_in[CORNERS+k] = c_t_ff[ROW_Y][k][COORD_W-1] ^ w[COORD_W-1];
      end
   end

   // quotient of at least 2^30 saturates; otherwise the top bits start below the divisor
   always_comb begin
      logic [NUM_W-1:0] n;
      for (int l = 0; l < LANES; l++) begin
         n = {d_num_ff[l], {COORD_FRAC_BITS{1'b0}}};
         ovf_in[l] = CMP_W'(n) >= {d_den_ff[l & 3], {QUOT_BITS{1'b0}}};
         rem0_in[l] = COORD_W'(n[NUM_W-1:QUOT_BITS]);
         nq0_in[l] = n[QUOT_BITS-1:0];
      end
   end

   // one restoring step per stage: dividend bits shift out, quotient bits shift in
   always_comb begin
      logic [COORD_W-1:0] r;
      logic [QUOT_BITS-1:0] q;
      logic [COORD_W-1:0] d;
      logic [COORD_W:0] trial;
      logic ge;
      for (int s = 0; s < QUOT_BITS; s++) begin
         for (int l = 0; l < LANES; l++) begin
            if (s == 0) begin
               r = e_rem_ff[l];
               q = e_nq_ff[l];
               d = e_den_ff[l & 3];
            end else begin
               r = dv_rem_ff[s-1][l];
               q = dv_nq_ff[s-1][l];
               d = dv_den_ff[s-1][l & 3];
            end
            trial = {r, q[QUOT_BITS-1]};
            ge = trial >= {1'b0, d};
            dv_rem_in[s][l] = ge ? COORD_W'(trial - {1'b0, d}) : trial[COORD_W-1:0];
            dv_nq_in[s][l] = {q[QUOT_BITS-2:0], ge};
         end
      end
   end

   always_comb begin
      logic [QUOT_BITS-1:0] mag;
      for (int l = 0; l < LANES; l++) begin
         mag = dv_ovf_ff[LAST][l] ? SCREEN_LIM : dv_nq_ff[LAST][l];
         s_in[l] = dv_sgn_ff[LAST][l] ? -COORD_W'(mag) : COORD_W'(mag);
      end
   end

   // sx in lanes 0..3, sy in lanes 4..7
   always_comb begin
      logic lft, rgt, top, bot;
      lft = 1'b1; rgt = 1'b1; top = 1'b1; bot = 1'b1;
      for (int k = 0; k < CORNERS; k++) begin
         lft = lft && (f_s_ff[k] <= -ONE);
         rgt = rgt && (f_s_ff[k] >= ONE);
         top = top && (f_s_ff[CORNERS+k] >= ONE);
         bot = bot && (f_s_ff[CORNERS+k] <= -ONE);
      end
      edge_in = lft || rgt || top || bot;
      // triangle 0,1,2
      d_in[0][0] = f_s_ff[1] - f_s_ff[0];
      d_in[0][1] = f_s_ff[CORNERS+1] - f_s_ff[CORNERS+0];
      d_in[0][2] = f_s_ff[2] - f_s_ff[1];
      d_in[0][3] = f_s_ff[CORNERS+2] - f_s_ff[CORNERS+1];
      // triangle 2,3,0
      d_in[1][0] = f_s_ff[3] - f_s_ff[2];
      d_in[1][1] = f_s_ff[CORNERS+3] - f_s_ff[CORNERS+2];
      d_in[1][2] = f_s_ff[0] - f_s_ff[3];
      d_in[1][3] = f_s_ff[CORNERS+0] - f_s_ff[CORNERS+3];
   end

   always_comb begin
      if (!h_same_ff) o_vis_in = 1'b1;
      else if ((h_m_ff[0] > h_n_ff[0]) && (h_m_ff[1] > h_n_ff[1]))
         o_vis_in = h_home_ff && h_fwd_ff;
      else o_vis_in = !h_edge_ff;
   end

   // stage valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
         d_valid_ff <= 1'b0;
         e_valid_ff <= 1'b0;
         for (int s = 0; s < QUOT_BITS; s++) dv_valid_ff[s] <= 1'b0;
         f_valid_ff <= 1'b0;
         g_valid_ff <= 1'b0;
         h_valid_ff <= 1'b0;
         o_valid_ff <= 1'b0;
      end else if (en) begin
         a_valid_ff <= req_chan.valid;
         b_valid_ff <= a_valid_ff;
         c_valid_ff <= b_valid_ff;
         d_valid_ff <= c_valid_ff;
         e_valid_ff <= d_valid_ff;
         dv_valid_ff[0] <= e_valid_ff;
         for (int s = 1; s < QUOT_BITS; s++) dv_valid_ff[s] <= dv_valid_ff[s-1];
         f_valid_ff <= dv_valid_ff[LAST];
         g_valid_ff <= f_valid_ff;
         h_valid_ff <= g_valid_ff;
         o_valid_ff <= h_valid_ff;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (en) begin
         a_ax_ff <= req_chan.corner_a_x;
         a_ay_ff <= req_chan.corner_a_y;
         a_bx_ff <= req_chan.corner_b_x;
         a_by_ff <= req_chan.corner_b_y;
         a_z0_ff <= req_chan.bottom_height;
         a_z1_ff <= req_chan.top_height;
         a_home_ff <= req_chan.from_home;
         a_dx_ff <= (COORD_W+1)'(req_chan.corner_b_x) - (COORD_W+1)'(req_chan.corner_a_x);
         a_dy_ff <= (COORD_W+1)'(req_chan.corner_b_y) - (COORD_W+1)'(req_chan.corner_a_y);

         b_p_ff <= prod_in;
         b_fdy_ff <= fdy_in;
         b_fdx_ff <= fdx_in;
         b_home_ff <= a_home_ff;

         c_t_ff <= t_in;
         c_fwd_ff <= (b_fdy_ff != b_fdx_ff);
         c_home_ff <= b_home_ff;

         d_num_ff <= num_in;
         d_den_ff <= den_in;
         d_sgn_ff <= sgn_in;
         d_pos_ff <= pos_in;
         d_neg_ff <= neg_in;
         d_fwd_ff <= c_fwd_ff;
         d_home_ff <= c_home_ff;

         e_ovf_ff <= ovf_in;
         e_rem_ff <= rem0_in;
         e_nq_ff <= nq0_in;
         e_sgn_ff <= d_sgn_ff;
         e_den_ff <= d_den_ff;
         e_same_ff <= d_pos_ff || d_neg_ff;
         e_fwd_ff <= d_fwd_ff;
         e_home_ff <= d_home_ff;

         dv_rem_ff <= dv_rem_in;
         dv_nq_ff <= dv_nq_in;
         dv_ovf_ff[0] <= e_ovf_ff;
         dv_sgn_ff[0] <= e_sgn_ff;
         dv_den_ff[0] <= e_den_ff;
         dv_same_ff[0] <= e_same_ff;
         dv_fwd_ff[0] <= e_fwd_ff;
         dv_home_ff[0] <= e_home_ff;
         for (int s = 1; s < QUOT_BITS; s++) begin
            dv_ovf_ff[s] <= dv_ovf_ff[s-1];
            dv_sgn_ff[s] <= dv_sgn_ff[s-1];
            dv_den_ff[s] <= dv_den_ff[s-1];
            dv_same_ff[s] <= dv_same_ff[s-1];
            dv_fwd_ff[s] <= dv_fwd_ff[s-1];
            dv_home_ff[s] <= dv_home_ff[s-1];
         end

         f_s_ff <= s_in;
         f_same_ff <= dv_same_ff[LAST];
         f_fwd_ff <= dv_fwd_ff[LAST];
         f_home_ff <= dv_home_ff[LAST];

         g_d_ff <= d_in;
         g_edge_ff <= edge_in;
         g_same_ff <= f_same_ff;
         g_fwd_ff <= f_fwd_ff;
         g_home_ff <= f_home_ff;

         for (int w = 0; w < 2; w++) begin
            h_m_ff[w] <= g_d_ff[w][0] * g_d_ff[w][3];
            h_n_ff[w] <= g_d_ff[w][1] * g_d_ff[w][2];
         end
         h_edge_ff <= g_edge_ff;
         h_same_ff <= g_same_ff;
         h_fwd_ff <= g_fwd_ff;
         h_home_ff <= g_home_ff;

         o_vis_ff <= o_vis_in;
         o_same_ff <= h_same_ff;
      end
   end

   `PQVT_ASSERT(accept_enters_pipe, (req_chan.valid && req_chan.ready) |=> a_valid_ff, "beat lost")
   `PQVT_NEVER(w_sign_conflict, d_valid_ff && d_pos_ff && d_neg_ff, "w seen with both signs")
   `PQVT_ASSERT(cull_needs_same_w, (rsp_chan.valid && !rsp_chan.visible) |-> o_same_ff, "bad cull")
endmodule
